@@ hw/rtl/inversion_counter_macros.svh @@
// Assertion helpers used by ic_core.
`ifndef INVERSION_COUNTER_MACROS_SVH
`define INVERSION_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ic_pkg.sv @@
package ic_pkg;

    // Payload widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 19;

    // Default capacity of the value store
    localparam int MAX_ITEMS_DEF = 1024;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    // Result beat from the core to the output register
    typedef struct packed {
        t_count inversion_count;
        logic   overflow;
    } t_result;

endpackage

@@ hw/rtl/ic_if.sv @@
// Input channel: one sequence element per beat
interface ic_in_if;
    logic             valid;
    logic             ready;
    ic_pkg::t_value   value;
    logic             last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// Result channel: one count per sequence
interface ic_out_if;
    logic             valid;
    logic             ready;
    ic_pkg::t_count   inversion_count;
    logic             overflow;

    modport source (output valid, output inversion_count, output overflow, input ready);
    modport sink   (input valid, input inversion_count, input overflow, output ready);
endinterface

@@ hw/rtl/ic_ram.sv @@
// Simple dual-port RAM, one write and one registered read port
module ic_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ic_core.sv @@
`include "inversion_counter_macros.svh"

// Sequencer: scans the stored values for each new value, keeps the running count
module ic_core #(
    parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ic_in_if.sink             i_in,
    output logic              o_res_valid,
    output ic_pkg::t_result   o_res,
    input  logic              i_res_ready
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int FW = $clog2(MAX_ITEMS + 1);
    localparam int SW = ic_pkg::COUNT_W + 1;
    localparam logic [FW-1:0] FULL = FW'(MAX_ITEMS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    ic_pkg::t_count  r_running, n_running;
    logic            r_ovf, n_ovf;
    ic_pkg::t_value  r_value, n_value;
    logic            r_last, n_last;
    logic [FW-1:0]   r_idx, n_idx;
    logic [FW-1:0]   r_found, n_found;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ic_pkg::VALUE_W-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ic_pkg::VALUE_W-1:0] ram_rdata;
    logic [SW-1:0]          sum;

    // Value store
    ic_ram #(
        .WIDTH (ic_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Saturating accumulate of this value's inversions
    assign sum = SW'(r_running) + SW'(r_found);

    // Next-state logic; reads and writes never share a cycle
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_running = r_running;
        n_ovf     = r_ovf;
        n_value   = r_value;
        n_last    = r_last;
        n_idx     = r_idx;
        n_found   = r_found;
        ram_we    = 1'b0;
        ram_waddr = r_fill[AW-1:0];
        ram_wdata = r_value;
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_value = i_in.value;
                    n_last  = i_in.last;
                    if (r_fill == FULL) begin
                        // store full: drop the beat
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_state = ST_EMIT;
                        end
                    end else if (r_fill == '0) begin
                        // first value: nothing to compare against
                        ram_we    = 1'b1;
                        ram_wdata = i_in.value;
                        n_fill    = r_fill + FW'(1);
                        if (i_in.last) begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_idx     = FW'(1);
                        n_found   = '0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read data belongs to the address issued last cycle
                if ($signed(ram_rdata) > r_value) begin
                    n_found = r_found + FW'(1);
                end
                if (r_idx == r_fill) begin
                    n_state = ST_COMMIT;
                end else begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + FW'(1);
                end
            end
            ST_COMMIT: begin
                ram_we    = 1'b1;
                n_fill    = r_fill + FW'(1);
                n_running = sum[SW-1] ? '1 : sum[SW-2:0];
                n_state   = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_fill    = '0;
                    n_running = '0;
                    n_ovf     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_running <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_running <= n_running;
            r_ovf     <= n_ovf;
        end
        r_value <= n_value;
        r_last  <= n_last;
        r_idx   <= n_idx;
        r_found <= n_found;
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_res_valid         = (r_state == ST_EMIT);
    assign o_res.inversion_count = r_running;
    assign o_res.overflow      = r_ovf;

    // Checks
    `IC_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, ram_we, !ram_re,
        "store read and write in the same cycle")
    `IC_ASSERT_IMP(a_read_in_range, i_clk, i_rst_n, ram_re,
        {1'b0, ram_raddr} < {1'b0, r_fill}, "store read beyond fill")
    `IC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL,
        "fill count above capacity")
    `IC_ASSERT_NXT(a_clear_after_emit, i_clk, i_rst_n,
        (r_state == ST_EMIT) && i_res_ready,
        (r_fill == '0) && (r_running == '0) && !r_ovf,
        "sequence state not cleared after result")

endmodule

@@ hw/rtl/inversion_counter.sv @@
// Inversion counter: counts pairs in a sequence of signed 32-bit values where an
// earlier value is strictly greater than a later one, and returns the count
// (saturating at 2^19-1) with an overflow flag on the beat marked last, then
// starts a new sequence. Up to MAX_ITEMS values are stored; later values of the
// same sequence are dropped and flagged. Each value is compared against every
// stored value of its sequence through the single read port of the value
// memory, one entry per cycle: a value with stored predecessors holds off the
// input while they are scanned and it is then written in a commit step; a first
// or dropped value is taken without a scan. The result of a sequence is handed
// to the output register, which holds it until taken while the next one runs.
module inversion_counter #(
    parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ic_in_if.sink    i_in,
    ic_out_if.source o_res
);

    logic            res_valid;
    logic            res_ready;
    ic_pkg::t_result res;
    logic            r_out_valid;
    ic_pkg::t_result r_out;

    ic_core #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ready(res_ready)
    );

    // Output register: takes a new result when empty or being drained
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.inversion_count = r_out.inversion_count;
    assign o_res.overflow        = r_out.overflow;

endmodule
